FILE: hdl/signed_unsigned_divider_64_defines.svh
// Assertion macros shared by the divider RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef SIGNED_UNSIGNED_DIVIDER_64_DEFINES_SVH
`define SIGNED_UNSIGNED_DIVIDER_64_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define SUD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// A condition that must never be seen outside reset.
`define SUD_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

FILE: hdl/sud64_pkg.sv
// Package for the signed/unsigned divider: field widths, command codes and
// the controller-to-datapath command struct. No dependencies.
`default_nettype none

package sud64_pkg;

    localparam int FIELD_W = 64;
    localparam int CMD_W   = 2;

    localparam logic [CMD_W-1:0] CMD_UQUO = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UREM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SQUO = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SREM = 2'd3;

    // Commands from the controller to the datapath, at most one per cycle.
    typedef struct packed {
        logic load;    // capture operands and form magnitudes
        logic step;    // one restoring shift-subtract iteration
        logic finish;  // select, sign-correct and register the result
    } t_dp_ctrl;

endpackage

`default_nettype wire

FILE: hdl/sud64_ifs.sv
// Valid/ready channel interfaces for the divider request and response.
// Depends on sud64_pkg for the field widths.
`default_nettype none

interface sud64_req_if;
    import sud64_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] dividend;
    logic [FIELD_W-1:0] divisor;

    modport source (output valid, output cmd, output dividend, output divisor,
                    input ready);
    modport sink   (input valid, input cmd, input dividend, input divisor,
                    output ready);
endinterface

interface sud64_rsp_if;
    import sud64_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

FILE: hdl/sud64_ctrl.sv
// Divider controller: state machine, iteration counter and output valid.
// Depends on sud64_pkg and the assertion macro header.
`default_nettype none
`include "signed_unsigned_divider_64_defines.svh"

module sud64_ctrl #(
    parameter int DATA_WIDTH = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output sud64_pkg::t_dp_ctrl  o_ctrl
);
    import sud64_pkg::*;

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ctrl      = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctrl.load = 1'b1;
                    n_cnt       = CNT_W'(DATA_WIDTH - 1);
                    n_state     = ST_RUN;
                end
            end
            ST_RUN: begin
                o_ctrl.step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            ST_FIN: begin
                // Wait here while the previous result is still unclaimed.
                if (w_slot_free) begin
                    o_ctrl.finish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `SUD_ASSERT(a_one_cmd, i_clk, i_rst_n,
        $countones(o_ctrl) <= 1, "several datapath commands")
    `SUD_ASSERT(a_fin_free, i_clk, i_rst_n,
        o_ctrl.finish |-> w_slot_free, "result overwritten")
    `SUD_ASSERT(a_load_cnt, i_clk, i_rst_n,
        o_ctrl.load |=> (r_cnt == CNT_W'(DATA_WIDTH - 1)), "bad count")
    `SUD_ASSERT(a_last_step, i_clk, i_rst_n,
        (o_ctrl.step && r_cnt == '0) |=> (r_state == ST_FIN), "no finish")
    `SUD_ASSERT_NEVER(a_busy_rdy, i_clk, i_rst_n,
        o_in_ready && (o_ctrl.step || o_ctrl.finish), "ready while busy")

endmodule

`default_nettype wire

FILE: hdl/sud64_dp.sv
// Divider datapath: operand magnitudes, restoring shift-subtract iteration
// and sign correction into the result register. Depends on sud64_pkg.
`default_nettype none

module sud64_dp #(
    parameter int DATA_WIDTH = 64
) (
    input  wire                          i_clk,
    input  sud64_pkg::t_dp_ctrl          i_ctrl,
    input  wire [sud64_pkg::CMD_W-1:0]   i_cmd,
    input  wire [sud64_pkg::FIELD_W-1:0] i_dividend,
    input  wire [sud64_pkg::FIELD_W-1:0] i_divisor,
    output logic [sud64_pkg::FIELD_W-1:0] o_result
);
    import sud64_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [W-1:0]       r_div, r_rem, r_quo;
    logic               r_want_rem, r_neg_q, r_neg_r, r_dz;
    logic [FIELD_W-1:0] r_result;

    logic [W-1:0] w_n, w_d, w_an, w_ad;
    logic         w_signed, w_want_rem, w_nn, w_dn;
    logic [W:0]   w_shift;
    logic [W+1:0] w_trial;
    logic [W-1:0] w_sel, w_val;
    logic         w_neg;

    always_comb begin
        w_n        = i_dividend[W-1:0];
        w_d        = i_divisor[W-1:0];
        w_signed   = i_cmd inside {CMD_SQUO, CMD_SREM};
        w_want_rem = i_cmd inside {CMD_UREM, CMD_SREM};
        w_nn       = w_signed && w_n[W-1];
        w_dn       = w_signed && w_d[W-1];
        w_an       = w_nn ? (~w_n + W'(1)) : w_n;
        w_ad       = w_dn ? (~w_d + W'(1)) : w_d;
    end

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
        w_shift = {r_rem, r_quo[W-1]};
        w_trial = {1'b0, w_shift} - {2'b00, r_div};
    end

    always_comb begin
        if (r_want_rem) begin
            w_sel = r_rem;
            w_neg = r_neg_r;
        end else begin
            w_sel = r_dz ? '0 : r_quo;
            w_neg = r_neg_q;
        end
        w_val = w_neg ? (~w_sel + W'(1)) : w_sel;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_div      <= w_ad;
            r_rem      <= '0;
            r_quo      <= w_an;
            r_want_rem <= w_want_rem;
            r_neg_q    <= w_nn ^ w_dn;
            r_neg_r    <= w_nn;
            r_dz       <= (w_d == '0);
        end else if (i_ctrl.step) begin
            if (!w_trial[W+1]) begin
                r_rem <= w_trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
        if (i_ctrl.finish) begin
            r_result <= FIELD_W'(w_val);
        end
    end

    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: hdl/signed_unsigned_divider_64.sv
// Top level of the signed/unsigned 64-bit divider: controller plus datapath.
// Depends on sud64_pkg, sud64_ifs, sud64_ctrl and sud64_dp.
`default_nettype none

// Channel  Dir  Fields                          Handshake
// i_req    in   cmd[1:0], dividend, divisor     valid/ready, taken when both high
// o_rsp    out  result                          valid/ready, taken when both high
//
// A transaction runs from acceptance to a valid result in order: the accepting edge loads
// the operand magnitudes, DATA_WIDTH iterations run the restoring shift-subtract loop and
// a final step sign-corrects the result into the output register. No new request is taken
// until the controller has registered that result and returned to idle.
// A waiting result does not block the input; a stalled output only holds the divider at
// its final step. Reset is synchronous, active low, and clears only the control state.
module signed_unsigned_divider_64 #(
    parameter int DATA_WIDTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    sud64_req_if.sink    i_req,
    sud64_rsp_if.source  o_rsp
);
    import sud64_pkg::*;

    // Command bundle from the state machine to the datapath.
    t_dp_ctrl w_ctrl;

    // The controller sequences load, DATA_WIDTH iterations and the final
    // correction, and owns both handshakes.
    sud64_ctrl #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_ctrl      (w_ctrl)
    );

    // The datapath holds the operands, the partial remainder, the quotient and
    // the result register; the bits above DATA_WIDTH of the result read zero.
    sud64_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_cmd      (i_req.cmd),
        .i_dividend (i_req.dividend),
        .i_divisor  (i_req.divisor),
        .o_result   (o_rsp.result)
    );

endmodule

`default_nettype wire

FILE: test/signed_unsigned_divider_64_checker.sv
// Result checker for the signed/unsigned 64-bit divider: watches both channels,
// predicts every result and compares it. Depends on sud64_pkg and sud64_ifs.
`default_nettype none

module signed_unsigned_divider_64_checker (
    input  wire   i_clk,
    input  wire   i_rst_n,
    sud64_req_if  i_req,
    sud64_rsp_if  i_rsp,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked
);
    import sud64_pkg::*;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [FIELD_W-1:0] dividend;
        logic [FIELD_W-1:0] divisor;
        logic [FIELD_W-1:0] result;
    } t_division;

    t_division awaited_divisions[$];
    t_division oldest;
    t_division incoming;
    int        fails = 0;
    int        checked = 0;

    // Signed forms divide magnitudes. The quotient is negated when the signs
    // differ, and the remainder follows the dividend's sign. A zero divisor
    // gives a zero quotient and hands the dividend back as the remainder.
    function automatic logic [FIELD_W-1:0] compute_division(
        input logic [CMD_W-1:0]   cmd,
        input logic [FIELD_W-1:0] dividend,
        input logic [FIELD_W-1:0] divisor
    );
        logic               want_rem;
        logic               is_signed;
        logic               dividend_neg;
        logic               divisor_neg;
        logic [FIELD_W-1:0] dividend_mag;
        logic [FIELD_W-1:0] divisor_mag;
        logic [FIELD_W-1:0] value;
        want_rem     = (cmd == CMD_UREM) || (cmd == CMD_SREM);
        is_signed    = (cmd == CMD_SQUO) || (cmd == CMD_SREM);
        dividend_neg = is_signed && dividend[FIELD_W-1];
        divisor_neg  = is_signed && divisor[FIELD_W-1];
        dividend_mag = dividend_neg ? -dividend : dividend;
        divisor_mag  = divisor_neg ? -divisor : divisor;
        if (divisor_mag == '0) begin
            value = want_rem ? dividend_mag : '0;
        end else begin
            value = want_rem ? dividend_mag % divisor_mag : dividend_mag / divisor_mag;
        end
        if (want_rem ? dividend_neg : (dividend_neg != divisor_neg)) begin
            value = -value;
        end
        return value;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // Compare before queueing, so a result never meets its own request.
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_divisions.size() == 0) begin
                    fails++;
                    $error("result %h arrived with no division outstanding", i_rsp.result);
                end else begin
                    oldest = awaited_divisions.pop_front();
                    checked++;
                    if (i_rsp.result !== oldest.result) begin
                        fails++;
                        $error("result mismatch (cmd %0d, dividend %h, divisor %h): expected %h, actual %h",
                               oldest.cmd, oldest.dividend, oldest.divisor,
                               oldest.result, i_rsp.result);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                incoming.cmd      = i_req.cmd;
                incoming.dividend = i_req.dividend;
                incoming.divisor  = i_req.divisor;
                incoming.result   = compute_division(i_req.cmd, i_req.dividend, i_req.divisor);
                awaited_divisions.push_back(incoming);
            end
        end
        o_fail_count <= fails;
        o_pending    <= awaited_divisions.size();
        o_checked    <= checked;
    end

endmodule

`default_nettype wire

FILE: test/signed_unsigned_divider_64_test.sv
// Top of the divider testbench: clock, reset, request stimulus, response
// back-pressure and the verdict. Depends on sud64_pkg, sud64_ifs, the divider
// RTL and signed_unsigned_divider_64_checker.
`default_nettype none

module signed_unsigned_divider_64_test;
    import sud64_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int RESET_CYCLES     = 8;
    localparam int RANDOM_DIVISIONS = 700;
    // Room for the load, every quotient-bit iteration and the finishing step,
    // plus some margin for the drain at the end of the run.
    localparam int DRAIN_CYCLES     = FIELD_W + 10;
    localparam int TIMEOUT_CYCLES   = 1_000_000;

    localparam logic [FIELD_W-1:0] ALL_ONES = '1;
    localparam logic [FIELD_W-1:0] MOST_NEG = {1'b1, {(FIELD_W-1){1'b0}}};
    localparam logic [FIELD_W-1:0] MAX_POS  = {1'b0, {(FIELD_W-1){1'b1}}};

    localparam logic [CMD_W-1:0] ALL_CMDS [4] = '{CMD_UQUO, CMD_UREM, CMD_SQUO, CMD_SREM};

    // Directed operand pairs. Each pair runs under every command. They cover
    // division by zero with a zero and a nonzero dividend, the most negative
    // dividend over minus one, the most negative value on both sides, and
    // mixed signs with a nonzero and a zero signed remainder.
    localparam logic [FIELD_W-1:0] DIRECTED_DIVIDENDS [6] = '{
        '0, ALL_ONES, MOST_NEG, MOST_NEG, -64'd100, MAX_POS
    };
    localparam logic [FIELD_W-1:0] DIRECTED_DIVISORS [6] = '{
        '0, '0, ALL_ONES, MOST_NEG, 64'd7, -64'd7
    };

    logic i_clk;
    logic i_rst_n;

    sud64_req_if req_if ();
    sud64_rsp_if rsp_if ();

    int fail_count;
    int pending_count;
    int checked_count;

    // Idle percentages for the two sides of the block. The request side is
    // only read by the stimulus process; the response side is changed with
    // nonblocking assignments so the back-pressure process sees it cleanly.
    int send_idle_pct = 20;
    int recv_idle_pct = 81;

    int cmd_sent [4];
    int directed_sent;
    int random_sent;

    signed_unsigned_divider_64 #(
        .DATA_WIDTH (FIELD_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    signed_unsigned_divider_64_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // The run is cut off here if the divider stops answering.
    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("Verification failed");
        $finish;
    end

    // Response back-pressure: ready is redrawn every cycle, so stalls land at random,
    // including the cycle a result appears.
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Operands are drawn from several shapes: zero, the extremes, small
    // magnitudes of either sign, random values cut to a random length (zero-
    // or sign-filled), and full-width random values. Mixing short and long
    // operands gives quotients of every length, remainders of every size and
    // a fair share of zero divisors.
    function automatic logic [FIELD_W-1:0] random_operand();
        logic [FIELD_W-1:0] value;
        value = {$urandom, $urandom};
        case ($urandom_range(9))
            0: value = '0;
            1: begin
                case ($urandom_range(3))
                    0:       value = ALL_ONES;
                    1:       value = MOST_NEG;
                    2:       value = MAX_POS;
                    default: value = FIELD_W'(1);
                endcase
            end
            2: value = FIELD_W'($urandom_range(256, 1));
            3: value = -FIELD_W'($urandom_range(256, 1));
            4, 5: value = value >> $urandom_range(FIELD_W - 1);
            6: value = $signed(value) >>> $urandom_range(FIELD_W - 1);
            default: ;
        endcase
        return value;
    endfunction

    // Presents one division and returns at the edge where it is taken. Valid
    // is only lowered when the sender chooses to idle, so back-to-back
    // transactions keep valid high without a glitch. Fields carry junk while
    // valid is low; the block must ignore it.
    task automatic send_division(
        input logic [CMD_W-1:0]   cmd,
        input logic [FIELD_W-1:0] dividend,
        input logic [FIELD_W-1:0] divisor
    );
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid    <= 1'b0;
            req_if.cmd      <= CMD_W'($urandom_range(3));
            req_if.dividend <= {$urandom, $urandom};
            req_if.divisor  <= {$urandom, $urandom};
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.cmd      <= cmd;
        req_if.dividend <= dividend;
        req_if.divisor  <= divisor;
        do @(posedge i_clk); while (!req_if.ready);
        cmd_sent[cmd]++;
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        req_if.valid    <= 1'b0;
        req_if.cmd      <= CMD_UQUO;
        req_if.dividend <= '0;
        req_if.divisor  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corner cases, each under all four commands.
        foreach (DIRECTED_DIVIDENDS[p]) begin
            foreach (ALL_CMDS[c]) begin
                send_division(ALL_CMDS[c], DIRECTED_DIVIDENDS[p], DIRECTED_DIVISORS[p]);
                directed_sent++;
            end
        end

        // Random divisions in three thirds: a mostly active sender with a mostly
        // stalled receiver, then the reverse, then both sides at full rate.
        for (int i = 0; i < RANDOM_DIVISIONS; i++) begin
            if (i == RANDOM_DIVISIONS / 3) begin
                send_idle_pct = 81;
                recv_idle_pct <= 20;
            end else if (i == 2 * RANDOM_DIVISIONS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            send_division(CMD_W'($urandom_range(3)), random_operand(), random_operand());
            random_sent++;
        end
        req_if.valid <= 1'b0;

        // The checker's counts are registered, so wait for the next edge before
        // trusting that nothing is outstanding.
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d directed and %0d random divisions sent, %0d results checked.",
                 directed_sent, random_sent, checked_count);
        $display("Commands: %0d unsigned quotient, %0d unsigned remainder, %0d signed quotient, %0d signed remainder.",
                 cmd_sent[CMD_UQUO], cmd_sent[CMD_UREM], cmd_sent[CMD_SQUO], cmd_sent[CMD_SREM]);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
